// ===== hdl/pjwh_pkg.sv =====
package pjwh_pkg;

  // Field and register widths.
  localparam int unsigned HASH_W  = 28;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned SIZE_W  = 17;

  // One remainder bit is resolved per division step.
  localparam int unsigned DIV_STEPS = HASH_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(256);
  localparam logic [IDX_W-1:0]  MAX_DIVISOR      = '1;

  // Fold constants of the shift-add-fold hash.
  localparam int unsigned FOLD_SHIFT = 4;
  localparam int unsigned FOLD_POS   = 4;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_FOLD = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic fold_en;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

  // One step of the hash: shift in a byte, fold the top nibble back, clear it.
  function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W+FOLD_SHIFT-1:0] x;
    logic [FOLD_SHIFT-1:0]        g;
    x = {h, {FOLD_SHIFT{1'b0}}} + {{(HASH_W+FOLD_SHIFT-BYTE_W){1'b0}}, b};
    g = x[HASH_W+FOLD_SHIFT-1:HASH_W];
    x[FOLD_POS+FOLD_SHIFT-1:FOLD_POS] = x[FOLD_POS+FOLD_SHIFT-1:FOLD_POS] ^ g;
    return x[HASH_W-1:0];
  endfunction

endpackage

// ===== hdl/pjwh_ctrl.sv =====
module pjwh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  pjwh_pkg::status_t status,
  output pjwh_pkg::cmd_t   cmd
);

  pjwh_pkg::state_t            state_r, state_nxt;
  logic [pjwh_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        in_fire;

  assign in_tready = (state_r == pjwh_pkg::S_FOLD);
  assign in_fire   = in_tvalid && in_tready;

  // Next state, step counter and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.fold_en  = 1'b0;
    cmd.div_load = 1'b0;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      pjwh_pkg::S_FOLD: begin
        if (in_fire) begin
          cmd.fold_en = 1'b1;
          if (in_tlast) begin
            cmd.div_load = 1'b1;
            cnt_nxt      = pjwh_pkg::CNT_W'(pjwh_pkg::DIV_STEPS);
            state_nxt    = pjwh_pkg::S_DIV;
          end
        end
      end
      pjwh_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == pjwh_pkg::CNT_W'(1)) begin
          state_nxt = pjwh_pkg::S_DONE;
        end
      end
      pjwh_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = pjwh_pkg::S_FOLD;
        end
      end
      default: begin
        state_nxt = pjwh_pkg::S_FOLD;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pjwh_pkg::S_FOLD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/pjwh_dpath.sv =====
module pjwh_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pjwh_pkg::BYTE_W-1:0]  char_byte,
  input  logic                         cfg_we,
  input  logic [pjwh_pkg::SIZE_W-1:0]  cfg_size,
  input  logic                         out_ready,
  input  pjwh_pkg::cmd_t               cmd,
  output pjwh_pkg::status_t            status,
  output logic                         out_valid,
  output logic [pjwh_pkg::IDX_W-1:0]   bucket_index
);

  logic [pjwh_pkg::SIZE_W-1:0] size_r;
  logic [pjwh_pkg::HASH_W-1:0] hash_r, hash_nxt, folded;
  logic [pjwh_pkg::HASH_W-1:0] dvd_r, dvd_nxt;
  logic [pjwh_pkg::IDX_W-1:0]  rem_r, rem_nxt;
  logic [pjwh_pkg::IDX_W-1:0]  div_r, div_nxt;
  logic                        zero_r, zero_nxt;
  logic [pjwh_pkg::IDX_W:0]    rem_shift;
  logic [pjwh_pkg::IDX_W:0]    rem_diff;
  logic                        rem_ge;
  logic [pjwh_pkg::IDX_W-1:0]  out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Table size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= pjwh_pkg::TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_size;
    end
  end

  // Running hash; cleared after the last character of a string.
  assign folded = pjwh_pkg::fold_byte(hash_r, char_byte);

  always_comb begin
    hash_nxt = hash_r;
    if (cmd.div_load) begin
      hash_nxt = '0;
    end else if (cmd.fold_en) begin
      hash_nxt = folded;
    end
  end

  // Divisor is the table size minus one, limited to 16 bits.
  always_comb begin
    zero_nxt = zero_r;
    div_nxt  = div_r;
    if (cmd.div_load) begin
      zero_nxt = (size_r[pjwh_pkg::SIZE_W-1:1] == '0);
      if (size_r[pjwh_pkg::SIZE_W-1]) begin
        div_nxt = pjwh_pkg::MAX_DIVISOR;
      end else begin
        div_nxt = size_r[pjwh_pkg::IDX_W-1:0] - 1'b1;
      end
    end
  end

  // Restoring remainder step: one dividend bit enters per cycle.
  assign rem_shift = {rem_r, dvd_r[pjwh_pkg::HASH_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, div_r});
  assign rem_diff  = rem_shift - {1'b0, div_r};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (cmd.div_load) begin
      dvd_nxt = folded;
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      dvd_nxt = {dvd_r[pjwh_pkg::HASH_W-2:0], 1'b0};
      rem_nxt = rem_ge ? rem_diff[pjwh_pkg::IDX_W-1:0] : rem_shift[pjwh_pkg::IDX_W-1:0];
    end
  end

  // Output register; a result waits here while the next string is folded.
  assign status.out_busy = out_valid_r && !out_ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_nxt       = zero_r ? '0 : rem_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    zero_r <= zero_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid    = out_valid_r;
  assign bucket_index = out_r;

endmodule

// ===== hdl/pjw_string_hash_index_unit.sv =====
// Throughput: one character per cycle within a string.
// After the last character the input stalls while the bit-serial
// remainder unit resolves 28 dividend bits, one per cycle, and the result loads.
// The stall runs longer while an earlier result still waits for out_tready.
// Reset (synchronous, rst_n low): table size 256, running hash 0, no result pending.
module pjw_string_hash_index_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] bucket_index
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // [16:0] table_size
);

  pjwh_pkg::cmd_t    cmd;
  pjwh_pkg::status_t status;

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  pjwh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pjwh_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_byte    (in_tdata),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_size     (cfg_data),
    .out_ready    (out_tready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_tvalid),
    .bucket_index (out_tdata)
  );

endmodule

// ===== verif/pjwh_checker.sv =====
`timescale 1ns / 100ps

module pjwh_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pjwh_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] char_byte
  input  logic                            in_tlast,   // last_char
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pjwh_pkg::IDX_W-1:0]      out_tdata,  // [15:0] bucket_index
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pjwh_pkg::SIZE_W-1:0]     cfg_data,   // [16:0] table_size
  output int                              n_expected,
  output int                              fail_count
);

  localparam int unsigned HASH_W = pjwh_pkg::HASH_W;
  localparam int unsigned BYTE_W = pjwh_pkg::BYTE_W;
  localparam int unsigned IDX_W  = pjwh_pkg::IDX_W;
  localparam int unsigned SIZE_W = pjwh_pkg::SIZE_W;

  localparam logic [31:0] ELF_TOP_MASK   = 32'hF000_0000;
  localparam int unsigned ELF_FOLD_SHIFT = 24;
  localparam logic [31:0] TABLE_SIZE_MAX = 32'd65536;

  logic [SIZE_W-1:0] table_size;
  logic [HASH_W-1:0] string_hash;
  logic [IDX_W-1:0]  expected_buckets[$];
  int                errs = 0;

  // Fold one character into the hash: shift-add in 32 bits, fold the top nibble
  // back in lower down, then clear the top nibble.
  function automatic logic [HASH_W-1:0] elf_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] c);
    logic [31:0] x;
    logic [31:0] top;
    x   = ({4'h0, h} << 4) + {24'h0, c};
    top = x & ELF_TOP_MASK;
    x   = x ^ (top >> ELF_FOLD_SHIFT);
    x   = x & ~top;
    return x[HASH_W-1:0];
  endfunction

  // Reduce the final hash to a bucket, modulo one less than the table size.
  // Tables below two entries give bucket 0; oversized tables are clamped.
  function automatic logic [IDX_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                 input logic [SIZE_W-1:0] size);
    logic [31:0] eff;
    logic [31:0] divisor;
    logic [31:0] rem;
    if (size < 2) begin
      return '0;
    end
    eff     = ({15'h0, size} > TABLE_SIZE_MAX) ? TABLE_SIZE_MAX : {15'h0, size};
    divisor = eff - 1;
    rem     = {4'h0, h} % divisor;
    return rem[IDX_W-1:0];
  endfunction

  // Track every transaction on the three channels. Results are checked before
  // new characters are taken, so a result never meets its own string.
  always @(posedge clk) begin
    logic [IDX_W-1:0] want;
    if (!rst_n) begin
      table_size  = pjwh_pkg::TABLE_SIZE_RESET;
      string_hash = '0;
      expected_buckets.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_size = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_buckets.size() == 0) begin
          errs = errs + 1;
          $display("%0t: unexpected bucket_index %0d with no result pending",
                   $time, out_tdata);
        end else begin
          want = expected_buckets.pop_front();
          if (out_tdata !== want) begin
            errs = errs + 1;
            $display("%0t: bucket_index mismatch: expected %0d, actual %0d",
                     $time, want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        string_hash = elf_fold(string_hash, in_tdata);
        if (in_tlast) begin
          expected_buckets.push_back(bucket_of(string_hash, table_size));
          string_hash = '0;
        end
      end
    end
    n_expected <= expected_buckets.size();
    fail_count <= errs;
  end

endmodule

// ===== verif/tb_pjw_string_hash_index_unit.sv =====
`timescale 1ns / 100ps

module tb_pjw_string_hash_index_unit;

  localparam int unsigned BYTE_W = pjwh_pkg::BYTE_W;
  localparam int unsigned IDX_W  = pjwh_pkg::IDX_W;
  localparam int unsigned SIZE_W = pjwh_pkg::SIZE_W;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 65;
  localparam int NUM_PHASES   = 13;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [BYTE_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tready = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic [SIZE_W-1:0] cfg_data   = '0;
  logic              in_tready;
  logic              out_tvalid;
  logic [IDX_W-1:0]  out_tdata;
  logic              cfg_ready;

  int n_expected;
  int fail_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_done      = 0;
  int cycle_count    = 0;

  pjw_string_hash_index_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pjwh_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .n_expected (n_expected),
    .fail_count (fail_count)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_done + 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one character and wait for its transaction.
  task automatic send_char(input logic [BYTE_W-1:0] c, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
  endtask

  // One key string of random content; mostly short, sometimes long enough
  // to push bits through the top-nibble fold several times.
  task automatic send_string(output int len);
    logic printable;
    len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(7, 1);
    printable = ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      send_char(printable ? BYTE_W'($urandom_range(126, 32)) : BYTE_W'($urandom_range(255)),
                i == len - 1);
    end
  endtask

  // Stop offering and wait until every pending bucket has come out and the
  // remainder unit has surely gone quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_expected != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned table_sizes[NUM_PHASES];
    int          sent;
    int          len;
    logic        paused;

    table_sizes = '{2, 65536, 0, 1, 65537, 131071, 3, 255, 65535, 4096, 17, 256, 0};
    table_sizes[NUM_PHASES-1] = $urandom_range(65535, 2);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings at the reset table size: zero and all-ones bytes, a string
    // that overflows into the top nibble, alternating bit patterns, a random string.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_char(8'hFF, i == 7);
    end
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h0F, 1'b0);
    send_char(8'hF0, 1'b1);
    for (int i = 0; i < 11; i++) begin
      send_char(BYTE_W'($urandom_range(255)), i == 10);
    end

    // Random phases, each at its own table size and idle pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_table_size(SIZE_W'(table_sizes[p]));
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 54;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct <= 6;
        end
      endcase
      // Long receiver hold-off while characters keep coming.
      if (p == 4 || p == 8) begin
        hold_req <= hold_req + 1;
      end
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        send_string(len);
        sent = sent + len;
        // In phase 6 the sender waits once for every outstanding bucket mid-phase.
        if (p == 6 && !paused && sent >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          drain();
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
